// ===== rtl/c2b_pkg.sv =====
// ----------------------------------------------------------------------------
// c2b_pkg
// Shared constants for the bearing pipeline: angle format, the arctangent
// table in degrees with 16 fractional bits, and the quadrant kind codes.
// ----------------------------------------------------------------------------
package c2b_pkg;

  localparam int ANGLE_FRAC = 16;
  localparam int GUARD_BITS = 8;
  localparam int TABLE_LEN  = 24;
  localparam int TBL_W      = 22;
  localparam int ZW         = 25;
  localparam int CLAMP_W    = 23;
  localparam int TOTAL_W    = 25;
  localparam int DEG_W      = 9;

  localparam logic [TBL_W-1:0] ATAN_DEG_Q16 [TABLE_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,
    22'd57,      22'd29,      22'd14,     22'd7,
    22'd4,       22'd2,       22'd1,      22'd0
  };

  localparam logic [TOTAL_W-1:0] DEG90_Q16  = 25'd5898240;
  localparam logic [TOTAL_W-1:0] DEG270_Q16 = 25'd17694720;
  localparam logic [TOTAL_W-1:0] DEG360_Q16 = 25'd23592960;

  localparam logic [DEG_W-1:0] DEG_UP    = 9'd0;
  localparam logic [DEG_W-1:0] DEG_RIGHT = 9'd90;
  localparam logic [DEG_W-1:0] DEG_DOWN  = 9'd180;
  localparam logic [DEG_W-1:0] DEG_LEFT  = 9'd270;

  localparam logic [2:0] KIND_FIXED = 3'd0;
  localparam logic [2:0] KIND_UR    = 3'd1;
  localparam logic [2:0] KIND_DR    = 3'd2;
  localparam logic [2:0] KIND_DL    = 3'd3;
  localparam logic [2:0] KIND_UL    = 3'd4;

endpackage

// ===== rtl/cartesian_to_bearing_degrees.sv =====
// ----------------------------------------------------------------------------
// cartesian_to_bearing_degrees
// Clockwise bearing from up, in whole degrees, of a signed screen offset,
// through a pipelined vectoring CORDIC.
//
// Usage: the input channel (in_valid, in_stall) carries one word of
// offset_x (right positive) and offset_y (down positive). The output
// channel (out_valid, out_stall) carries bearing_deg, 0..359, truncated.
// A word is taken at a clock edge where valid is high and stall is low.
// The pipeline (at most 24 CORDIC stages are built) has one input stage
// that sorts the quadrant, one register per CORDIC iteration, one stage
// that clamps and places the angle, and the output register. One word is
// accepted every cycle while in_stall is low; the rate is set by the
// one-iteration-per-stage CORDIC chain.
// When the receiver stalls, the result holds on the outputs and each stage
// holds only if the stage after it is full, so empty slots fill up before
// in_stall rises. Reset empties the pipeline; no result is lost or repeated.
// ----------------------------------------------------------------------------
module cartesian_to_bearing_degrees #(
  parameter int COORD_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] offset_x,
  input  logic signed [COORD_WIDTH-1:0] offset_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [c2b_pkg::DEG_W-1:0]     bearing_deg
);

  localparam int N  = (CORDIC_STAGES < c2b_pkg::TABLE_LEN) ?
                      CORDIC_STAGES : c2b_pkg::TABLE_LEN;
  localparam int XW = COORD_WIDTH + c2b_pkg::GUARD_BITS + 2;
  localparam int ZW = c2b_pkg::ZW;

  // pipeline registers, index 0 is the input stage
  logic                  v      [0:N];
  logic                  rdy    [0:N];
  logic signed [XW-1:0]  x_r    [0:N];
  logic signed [XW-1:0]  y_r    [0:N];
  logic signed [ZW-1:0]  z_r    [0:N];
  logic [2:0]            kind_r [0:N];
  logic [c2b_pkg::DEG_W-1:0] deg_r [0:N];

  logic signed [XW-1:0]  x_next [1:N];
  logic signed [XW-1:0]  y_next [1:N];
  logic signed [ZW-1:0]  z_next [1:N];

  logic                  fin_v;
  logic                  fin_rdy;
  logic                  out_rdy;
  logic [c2b_pkg::TOTAL_W-1:0] fin_total;
  logic [c2b_pkg::TOTAL_W-1:0] total_next;
  logic [c2b_pkg::TOTAL_W-1:0] wrap;
  logic [c2b_pkg::CLAMP_W-1:0] zc;

  // input classification
  logic [COORD_WIDTH-1:0] ax, ay, a_in, b_in;
  logic                   x_zero, y_zero, x_neg, y_neg;
  logic [2:0]             kind_in;
  logic [c2b_pkg::DEG_W-1:0] deg_in;

  // ready chain
  assign out_rdy  = !out_valid || !out_stall;
  assign fin_rdy  = !fin_v || out_rdy;
  assign in_stall = !rdy[0];

  always_comb begin
    rdy[N] = !v[N] || fin_rdy;
    for (int i = N - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  // quadrant sort
  always_comb begin
    x_neg  = offset_x[COORD_WIDTH-1];
    y_neg  = offset_y[COORD_WIDTH-1];
    x_zero = (offset_x == '0);
    y_zero = (offset_y == '0);
    ax     = x_neg ? (~offset_x + 1'b1) : offset_x;
    ay     = y_neg ? (~offset_y + 1'b1) : offset_y;
    a_in   = ax;
    b_in   = ay;
    deg_in = c2b_pkg::DEG_UP;
    if (x_zero && y_zero) begin
      kind_in = c2b_pkg::KIND_FIXED;
    end else if (y_zero) begin
      kind_in = c2b_pkg::KIND_FIXED;
      deg_in  = x_neg ? c2b_pkg::DEG_LEFT : c2b_pkg::DEG_RIGHT;
    end else if (x_zero) begin
      kind_in = c2b_pkg::KIND_FIXED;
      deg_in  = y_neg ? c2b_pkg::DEG_UP : c2b_pkg::DEG_DOWN;
    end else if (!x_neg && y_neg) begin
      kind_in = c2b_pkg::KIND_UR;
      a_in    = ay;
      b_in    = ax;
    end else if (!x_neg) begin
      kind_in = c2b_pkg::KIND_DR;
    end else if (!y_neg) begin
      kind_in = c2b_pkg::KIND_DL;
    end else begin
      kind_in = c2b_pkg::KIND_UL;
    end
  end

  // one cordic iteration per stage
  always_comb begin
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    for (int i = 0; i < N; i++) begin
      xs = x_r[i] >>> i;
      ys = y_r[i] >>> i;
      at = $signed({{(ZW - c2b_pkg::TBL_W){1'b0}}, c2b_pkg::ATAN_DEG_Q16[i]});
      if (y_r[i][XW-1]) begin
        x_next[i+1] = x_r[i] - ys;
        y_next[i+1] = y_r[i] + xs;
        z_next[i+1] = z_r[i] - at;
      end else if (y_r[i] != '0) begin
        x_next[i+1] = x_r[i] + ys;
        y_next[i+1] = y_r[i] - xs;
        z_next[i+1] = z_r[i] + at;
      end else begin
        x_next[i+1] = x_r[i];
        y_next[i+1] = y_r[i];
        z_next[i+1] = z_r[i];
      end
    end
  end

  // clamp and place in quadrant
  always_comb begin
    if (z_r[N][ZW-1]) begin
      zc = '0;
    end else if ($unsigned(z_r[N]) > c2b_pkg::DEG90_Q16) begin
      zc = c2b_pkg::DEG90_Q16[c2b_pkg::CLAMP_W-1:0];
    end else begin
      zc = z_r[N][c2b_pkg::CLAMP_W-1:0];
    end
    unique case (kind_r[N])
      c2b_pkg::KIND_UR: total_next = {2'b00, zc};
      c2b_pkg::KIND_DR: total_next = c2b_pkg::DEG90_Q16 + {2'b00, zc};
      c2b_pkg::KIND_DL: total_next = c2b_pkg::DEG270_Q16 - {2'b00, zc};
      c2b_pkg::KIND_UL: total_next = c2b_pkg::DEG270_Q16 + {2'b00, zc};
      default:          total_next = {deg_r[N], {c2b_pkg::ANGLE_FRAC{1'b0}}};
    endcase
  end

  assign wrap = (fin_total >= c2b_pkg::DEG360_Q16) ?
                (fin_total - c2b_pkg::DEG360_Q16) : fin_total;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= N; i++) begin
        v[i] <= 1'b0;
      end
      fin_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i <= N; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
      if (fin_rdy) begin
        fin_v <= v[N];
      end
      if (out_rdy) begin
        out_valid <= fin_v;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      x_r[0]    <= $signed({2'b00, a_in, {c2b_pkg::GUARD_BITS{1'b0}}});
      y_r[0]    <= $signed({2'b00, b_in, {c2b_pkg::GUARD_BITS{1'b0}}});
      z_r[0]    <= '0;
      kind_r[0] <= kind_in;
      deg_r[0]  <= deg_in;
    end
    for (int i = 1; i <= N; i++) begin
      if (rdy[i] && v[i-1]) begin
        x_r[i]    <= x_next[i];
        y_r[i]    <= y_next[i];
        z_r[i]    <= z_next[i];
        kind_r[i] <= kind_r[i-1];
        deg_r[i]  <= deg_r[i-1];
      end
    end
    if (fin_rdy && v[N]) begin
      fin_total <= total_next;
    end
    if (out_rdy && fin_v) begin
      bearing_deg <= wrap[c2b_pkg::TOTAL_W-1:c2b_pkg::ANGLE_FRAC];
    end
  end

endmodule
